FILE: hdl/assert_macros.svh
// Assertion macros shared by the task dispatcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Plain property, checked at every rising edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Overlapping implication: when ante holds, cons holds in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hdl/ptd_pkg.sv
// Types and codes shared by the periodic task dispatcher modules.
`default_nettype none
package ptd_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_ADD   = 2'd1,
    OP_RUN   = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_NONE   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_TICK_DRAIN,
    S_RUN_RD,
    S_RUN_WR
  } state_e;

  typedef struct packed {
    op_e         operation;
    logic [31:0] period;
    logic        handler_valid;
  } ptd_in_t;

  typedef struct packed {
    status_e     status;
    logic [2:0]  task_index;
    logic [31:0] tick_count;
    logic        last_of_run;
  } ptd_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic do_tick;
    logic do_add;
    logic do_clear;
    logic do_run_none;
    logic tick_rd;
    logic run_rd;
    logic run_wr;
  } ptd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic table_empty;
    logic any_ready;
    logic tick_last;
    logic more_ready;
  } ptd_stat_t;

endpackage
`default_nettype wire

FILE: hdl/periodic_task_dispatcher.sv
// Every result is registered and appears in the cycle after the step that forms it.
// Add, clear, tick and an empty run are handled in the step that accepts them; with slots
// added, a tick then walks the countdown table one slot per cycle, holding off the input
// until the walk and a drain state are done. A run handles each ready slot with a period
// read, then a reload and result, each result also waiting for the previous one to be taken.
// Reset (rst_ni low, asynchronous) empties the table and zeroes the tick counter.
`default_nettype none
module periodic_task_dispatcher import ptd_pkg::*; #(
  parameter int unsigned TASK_SLOTS = 8
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire ptd_in_t in_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output ptd_out_t     out_o
);

  // The controller decodes each accepted item and steps the slot walks; the
  // datapath holds the tables, the ready flags and the result register.
  ptd_cmd_t  cmd;
  ptd_stat_t stat;

  ptd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_i.operation),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // There is a single result register: while a result waits in it, the next item
  // is held off unless the waiting result is taken in that same cycle.
  ptd_dpath #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire

FILE: hdl/ptd_ctrl.sv
// Sequencing state machine of the periodic task dispatcher.
`default_nettype none
`include "assert_macros.svh"
module ptd_ctrl import ptd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire op_e       in_op_i,
  output logic           in_ready_o,
  input  wire ptd_stat_t stat_i,
  output ptd_cmd_t       cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_op_i == OP_TICK && !stat_i.table_empty) begin
            state_d = S_TICK;
          end else if (in_op_i == OP_RUN && stat_i.any_ready) begin
            state_d = S_RUN_RD;
          end
        end
      end
      S_TICK: begin
        if (stat_i.tick_last) begin
          state_d = S_TICK_DRAIN;
        end
      end
      S_TICK_DRAIN: state_d = S_IDLE;
      S_RUN_RD:     state_d = S_RUN_WR;
      S_RUN_WR: begin
        if (stat_i.out_free) begin
          state_d = stat_i.more_ready ? S_RUN_RD : S_IDLE;
        end
      end
      default:      state_d = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = stat_i.out_free;
        if (accept) begin
          unique case (in_op_i)
            OP_TICK:  cmd_o.do_tick  = 1'b1;
            OP_ADD:   cmd_o.do_add   = 1'b1;
            OP_CLEAR: cmd_o.do_clear = 1'b1;
            OP_RUN:   cmd_o.do_run_none = !stat_i.any_ready;
            default:  cmd_o = '0;
          endcase
        end
      end
      S_TICK:       cmd_o.tick_rd = 1'b1;
      S_TICK_DRAIN: cmd_o = '0;
      S_RUN_RD:     cmd_o.run_rd = 1'b1;
      S_RUN_WR:     cmd_o.run_wr = stat_i.out_free;
      default:      cmd_o = '0;
    endcase
  end

  `ASSERT_AT(a_cmd_onehot, clk_i, rst_ni,
    $onehot0({cmd_o.do_tick, cmd_o.do_add, cmd_o.do_clear, cmd_o.do_run_none,
              cmd_o.tick_rd, cmd_o.run_rd, cmd_o.run_wr}),
    "controller issued two commands at once")
  `ASSERT_NEXT(a_rd_then_wr, clk_i, rst_ni, cmd_o.run_rd, state_q == S_RUN_WR,
    "run read not followed by its write-back")
  `ASSERT_IMPL(a_idle_only_accept, clk_i, rst_ni, in_ready_o,
    state_q == S_IDLE && stat_i.out_free, "item accepted while busy")

endmodule
`default_nettype wire

FILE: hdl/ptd_dpath.sv
// Datapath of the periodic task dispatcher: slot tables, counters, result register.
`default_nettype none
`include "assert_macros.svh"
module ptd_dpath import ptd_pkg::*; #(
  parameter int unsigned TASK_SLOTS = 8
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire ptd_in_t  in_i,
  input  wire logic     out_ready_i,
  input  wire ptd_cmd_t cmd_i,
  output ptd_stat_t     stat_o,
  output logic          out_valid_o,
  output ptd_out_t      out_o
);

  localparam int unsigned IdxW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(TASK_SLOTS + 1);

  logic [31:0]           tick_q, tick_d;
  logic [CntW-1:0]       added_q, added_d;
  logic [TASK_SLOTS-1:0] ready_q, ready_d;
  logic [IdxW-1:0]       ptr_q;
  logic                  wb_vld_q;
  logic [IdxW-1:0]       wb_idx_q;
  logic [IdxW-1:0]       sel_q;
  logic [31:0]           cd_rdata_q;
  logic [31:0]           per_rdata_q;
  logic                  out_vld_q;
  ptd_out_t              out_q, out_d;

  logic [31:0] period_mem [TASK_SLOTS];
  logic [31:0] cd_mem     [TASK_SLOTS];

  logic [IdxW-1:0]       add_idx;
  logic                  add_ok;
  logic [IdxW-1:0]       first_idx;
  logic [TASK_SLOTS-1:0] rest;
  logic                  more_ready;
  logic [31:0]           cd_dec;
  logic                  wb_blocked;
  logic                  cd_we;
  logic [IdxW-1:0]       cd_wa;
  logic [31:0]           cd_wd;
  logic [IdxW-1:0]       idx_sel;
  logic [IdxW+2:0]       idx_ext;
  logic                  out_load;

  assign add_idx = added_q[IdxW-1:0];
  assign add_ok  = in_i.handler_valid && (added_q != CntW'(TASK_SLOTS));

  // Lowest ready slot.
  always_comb begin
    first_idx = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (ready_q[i]) begin
        first_idx = IdxW'(i);
      end
    end
  end

  always_comb begin
    rest        = ready_q;
    rest[sel_q] = 1'b0;
  end
  assign more_ready = |rest;

  // Countdown write-back for the tick walk: saturate at zero.
  assign cd_dec     = (cd_rdata_q == 32'd0) ? 32'd0 : cd_rdata_q - 32'd1;
  assign wb_blocked = wb_vld_q && !ready_q[wb_idx_q];

  always_comb begin
    cd_we = 1'b0;
    cd_wa = wb_idx_q;
    cd_wd = cd_dec;
    if (cmd_i.do_add && add_ok) begin
      cd_we = 1'b1;
      cd_wa = add_idx;
      cd_wd = in_i.period;
    end else if (cmd_i.run_wr) begin
      cd_we = 1'b1;
      cd_wa = sel_q;
      cd_wd = per_rdata_q;
    end else if (wb_blocked) begin
      cd_we = 1'b1;
    end
  end

  always_comb begin
    ready_d = ready_q;
    if (cmd_i.do_clear) begin
      ready_d = '0;
    end
    if (cmd_i.do_add && add_ok) begin
      ready_d[add_idx] = 1'b0;
    end
    if (cmd_i.run_wr) begin
      ready_d[sel_q] = 1'b0;
    end
    if (wb_blocked && cd_dec == 32'd0) begin
      ready_d[wb_idx_q] = 1'b1;
    end
  end

  always_comb begin
    added_d = added_q;
    tick_d  = tick_q;
    if (cmd_i.do_clear) begin
      added_d = '0;
      tick_d  = '0;
    end
    if (cmd_i.do_add && add_ok) begin
      added_d = added_q + CntW'(1);
    end
    if (cmd_i.do_tick) begin
      tick_d = tick_q + 32'd1;
    end
  end

  // Result assembly.
  assign idx_sel  = cmd_i.run_wr ? sel_q : add_idx;
  assign idx_ext  = {3'b000, idx_sel};
  assign out_load = cmd_i.do_tick | cmd_i.do_add | cmd_i.do_clear | cmd_i.do_run_none |
                    cmd_i.run_wr;

  always_comb begin
    out_d.status      = ST_OK;
    out_d.task_index  = '0;
    out_d.tick_count  = tick_q;
    out_d.last_of_run = 1'b1;
    if (cmd_i.do_tick) begin
      out_d.tick_count = tick_q + 32'd1;
    end
    if (cmd_i.do_clear) begin
      out_d.tick_count = '0;
    end
    if (cmd_i.do_run_none) begin
      out_d.status = ST_NONE;
    end
    if (cmd_i.do_add) begin
      if (add_ok) begin
        out_d.task_index = idx_ext[2:0];
      end else begin
        out_d.status = ST_REJECT;
      end
    end
    if (cmd_i.run_wr) begin
      out_d.task_index  = idx_ext[2:0];
      out_d.last_of_run = !more_ready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q    <= '0;
      added_q   <= '0;
      ready_q   <= '0;
      ptr_q     <= '0;
      wb_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      tick_q   <= tick_d;
      added_q  <= added_d;
      ready_q  <= ready_d;
      wb_vld_q <= cmd_i.tick_rd;
      if (cmd_i.do_tick) begin
        ptr_q <= '0;
      end else if (cmd_i.tick_rd) begin
        ptr_q <= ptr_q + IdxW'(1);
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
    if (cmd_i.tick_rd) begin
      wb_idx_q <= ptr_q;
    end
    if (cmd_i.run_rd) begin
      sel_q <= first_idx;
    end
  end

  // Period table: written by add, read by run.
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_add && add_ok) begin
      period_mem[add_idx] <= in_i.period;
    end
    if (cmd_i.run_rd) begin
      per_rdata_q <= period_mem[first_idx];
    end
  end

  // Countdown table: read by the tick walk, written by add, tick and run.
  always_ff @(posedge clk_i) begin
    if (cd_we) begin
      cd_mem[cd_wa] <= cd_wd;
    end
    if (cmd_i.tick_rd) begin
      cd_rdata_q <= cd_mem[ptr_q];
    end
  end

  assign stat_o.out_free    = !out_vld_q || out_ready_i;
  assign stat_o.table_empty = (added_q == '0);
  assign stat_o.any_ready   = |ready_q;
  assign stat_o.tick_last   = (CntW'(ptr_q) == added_q - CntW'(1));
  assign stat_o.more_ready  = more_ready;

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  `ASSERT_IMPL(a_run_sel_ready, clk_i, rst_ni, cmd_i.run_wr, ready_q[sel_q],
    "dispatched slot is not ready")
  `ASSERT_AT(a_added_bound, clk_i, rst_ni, added_q <= CntW'(TASK_SLOTS),
    "slot count beyond table size")
  `ASSERT_AT(a_no_wb_clash, clk_i, rst_ni, !(wb_vld_q && (cmd_i.do_add || cmd_i.run_wr)),
    "countdown write port contention")

endmodule
`default_nettype wire

FILE: dv/periodic_task_dispatcher_tb.sv
// Self-checking testbench for the periodic task dispatcher: directed table, then random traffic.
module periodic_task_dispatcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptd_pkg::*;

  localparam int unsigned TASK_SLOTS = 8;
  localparam int RANDOM_ITEMS = 150;
  // The random part stops at this item and waits for the block to drain completely.
  localparam int DRAIN_PAUSE_AT = 100;
  // Once this many results have been taken, the receiver holds off for a long stretch.
  localparam int HOLD_AFTER_RESULTS = 40;
  localparam int HOLD_CYCLES = 250;
  // A tick holds the input only while it walks the table, and a full run only while it
  // dispatches the ready slots. The limit still has to ride out the long receiver hold,
  // plus margin.
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;

  // Slot modes as the scheduler keeps them.
  typedef enum logic [1:0] {
    MODE_SUSPENDED = 2'd0,
    MODE_BLOCKED   = 2'd1,
    MODE_READY     = 2'd2
  } slot_mode_e;

  // One row of the directed table. When typed is set, the row carries the single
  // result that it must produce; otherwise the scheduler predictor supplies it.
  typedef struct packed {
    op_e         operation;
    logic [31:0] period;
    logic        handler_valid;
    logic        typed;
    status_e     status;
    logic [2:0]  task_index;
    logic [31:0] tick_count;
  } step_row_t;

  localparam int DIRECTED_STEPS = 25;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  ptd_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  ptd_out_t out_data;

  // Scheduler state as predicted by the testbench.
  logic [31:0] slot_period [TASK_SLOTS];
  logic [31:0] slot_countdown [TASK_SLOTS];
  slot_mode_e  slot_mode [TASK_SLOTS];
  int unsigned slots_filled;
  logic [31:0] tick_total;

  // Results of the step just predicted, and every result still owed by the block.
  ptd_out_t step_results [$];
  ptd_out_t due_results [$];

  int errors          = 0;
  int results_seen    = 0;
  int idle_cycles     = 0;
  int burst_left      = 0;
  int op_counts [4]   = '{0, 0, 0, 0};
  int rejected_adds   = 0;
  int idle_runs       = 0;
  int most_dispatched = 0;
  bit long_hold_done  = 1'b0;

  // The table starts from reset: an empty run, a tick, a rejected add, then the table
  // is filled with periods zero, all ones and small values, overfilled, and worked by
  // ticks and runs. Zero-period slots and the period-one slots go ready on the first tick,
  // so the first run dispatches several slots at once. A clear, an empty run and an add end it.
  step_row_t directed_steps [DIRECTED_STEPS] = '{
    '{OP_RUN,   32'd0,          1'b0, 1'b1, ST_NONE,   3'd0, 32'd0},
    '{OP_TICK,  32'd0,          1'b0, 1'b1, ST_OK,     3'd0, 32'd1},
    '{OP_ADD,   32'd0,          1'b0, 1'b1, ST_REJECT, 3'd0, 32'd1},
    '{OP_ADD,   32'd0,          1'b1, 1'b1, ST_OK,     3'd0, 32'd1},
    '{OP_ADD,   32'hFFFF_FFFF,  1'b1, 1'b1, ST_OK,     3'd1, 32'd1},
    '{OP_ADD,   32'd1,          1'b1, 1'b1, ST_OK,     3'd2, 32'd1},
    '{OP_ADD,   32'd2,          1'b1, 1'b1, ST_OK,     3'd3, 32'd1},
    '{OP_ADD,   32'd3,          1'b1, 1'b1, ST_OK,     3'd4, 32'd1},
    '{OP_ADD,   32'd4,          1'b1, 1'b1, ST_OK,     3'd5, 32'd1},
    '{OP_ADD,   32'd1,          1'b1, 1'b1, ST_OK,     3'd6, 32'd1},
    '{OP_ADD,   32'd0,          1'b1, 1'b1, ST_OK,     3'd7, 32'd1},
    '{OP_ADD,   32'd9,          1'b1, 1'b1, ST_REJECT, 3'd0, 32'd1},
    '{OP_ADD,   32'd0,          1'b0, 1'b1, ST_REJECT, 3'd0, 32'd1},
    '{OP_TICK,  32'd0,          1'b0, 1'b0, ST_OK,     3'd0, 32'd0},
    '{OP_RUN,   32'd0,          1'b0, 1'b0, ST_OK,     3'd0, 32'd0},
    '{OP_RUN,   32'd0,          1'b0, 1'b0, ST_OK,     3'd0, 32'd0},
    '{OP_TICK,  32'd0,          1'b0, 1'b0, ST_OK,     3'd0, 32'd0},
    '{OP_TICK,  32'd0,          1'b0, 1'b0, ST_OK,     3'd0, 32'd0},
    '{OP_TICK,  32'd0,          1'b0, 1'b0, ST_OK,     3'd0, 32'd0},
    '{OP_RUN,   32'd0,          1'b0, 1'b0, ST_OK,     3'd0, 32'd0},
    '{OP_TICK,  32'd0,          1'b0, 1'b0, ST_OK,     3'd0, 32'd0},
    '{OP_RUN,   32'd0,          1'b0, 1'b0, ST_OK,     3'd0, 32'd0},
    '{OP_CLEAR, 32'd0,          1'b0, 1'b1, ST_OK,     3'd0, 32'd0},
    '{OP_RUN,   32'd0,          1'b0, 1'b1, ST_NONE,   3'd0, 32'd0},
    '{OP_ADD,   32'd0,          1'b1, 1'b1, ST_OK,     3'd0, 32'd0}
  };

  periodic_task_dispatcher #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_data)
  );

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  // Empties the predicted table and zeroes the tick counter, as reset and clear do.
  function automatic void clear_schedule();
    for (int i = 0; i < TASK_SLOTS; i++) begin
      slot_period[i]    = '0;
      slot_countdown[i] = '0;
      slot_mode[i]      = MODE_SUSPENDED;
    end
    slots_filled = 0;
    tick_total   = '0;
  endfunction

  // Appends one result to the current step; the tick count is always the value after the step.
  function automatic void emit_result(status_e status, logic [2:0] index, logic last);
    ptd_out_t res;
    res.status      = status;
    res.task_index  = index;
    res.tick_count  = tick_total;
    res.last_of_run = last;
    step_results.push_back(res);
  endfunction

  // Advances the predicted scheduler by one item and leaves its results in step_results.
  function automatic void schedule_step(ptd_in_t item);
    ptd_out_t tail;
    step_results.delete();
    case (item.operation)
      OP_TICK: begin
        // The counter wraps modulo 2^32 through the 32-bit arithmetic.
        tick_total = tick_total + 32'd1;
        for (int i = 0; i < slots_filled; i++) begin
          if (slot_mode[i] == MODE_BLOCKED) begin
            // A zero countdown stays at zero and goes ready right away.
            if (slot_countdown[i] != '0) slot_countdown[i] = slot_countdown[i] - 32'd1;
            if (slot_countdown[i] == '0) slot_mode[i] = MODE_READY;
          end
        end
        emit_result(ST_OK, 3'd0, 1'b1);
      end
      OP_ADD: begin
        if (slots_filled >= TASK_SLOTS || !item.handler_valid) begin
          emit_result(ST_REJECT, 3'd0, 1'b1);
        end else begin
          slot_mode[slots_filled]      = MODE_BLOCKED;
          slot_period[slots_filled]    = item.period;
          slot_countdown[slots_filled] = item.period;
          emit_result(ST_OK, 3'(slots_filled), 1'b1);
          slots_filled++;
        end
      end
      OP_RUN: begin
        for (int i = 0; i < slots_filled; i++) begin
          if (slot_mode[i] == MODE_READY) begin
            slot_countdown[i] = slot_period[i];
            slot_mode[i]      = MODE_BLOCKED;
            emit_result(ST_OK, 3'(i), 1'b0);
          end
        end
        if (step_results.size() == 0) begin
          emit_result(ST_NONE, 3'd0, 1'b1);
        end else begin
          // Only the final dispatch of a run is flagged as the last one.
          tail = step_results.pop_back();
          tail.last_of_run = 1'b1;
          step_results.push_back(tail);
        end
      end
      default: begin
        clear_schedule();
        emit_result(ST_OK, 3'd0, 1'b1);
      end
    endcase
  endfunction

  // Offers one item to the block, in bursts separated by random gaps, and records
  // what the block owes for it once the handshake completes. A typed row replaces
  // the predicted result by the one written in the table.
  task automatic offer_item(input ptd_in_t item, input bit typed, input ptd_out_t typed_res);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
      // Now and then a long burst with no gaps at all.
      burst_left = ($urandom_range(7, 0) == 0) ? 40 : $urandom_range(12, 1);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    // Valid is held high, so acceptance is the ready seen at the edge.
    do @(posedge clk_i); while (!in_ready);
    schedule_step(item);
    op_counts[item.operation]++;
    if (step_results[0].status == ST_REJECT) rejected_adds++;
    if (step_results[0].status == ST_NONE) idle_runs++;
    if (item.operation == OP_RUN && step_results[0].status == ST_OK &&
        step_results.size() > most_dispatched) begin
      most_dispatched = step_results.size();
    end
    if (typed) begin
      due_results.push_back(typed_res);
    end else begin
      foreach (step_results[k]) due_results.push_back(step_results[k]);
    end
  endtask

  // Sender: reset, the directed table, then random traffic.
  initial begin : stimulus
    ptd_in_t  item;
    ptd_out_t typed_res;
    int       pick;
    clear_schedule();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_steps[k]) begin
      item.operation        = directed_steps[k].operation;
      item.period           = directed_steps[k].period;
      item.handler_valid    = directed_steps[k].handler_valid;
      typed_res.status      = directed_steps[k].status;
      typed_res.task_index  = directed_steps[k].task_index;
      typed_res.tick_count  = directed_steps[k].tick_count;
      typed_res.last_of_run = 1'b1;
      offer_item(item, directed_steps[k].typed, typed_res);
    end

    // Random traffic mixes ticks, runs and adds, the adds mostly with short periods, so
    // slots keep going ready and runs dispatch several at once. Rare clears empty the
    // table again; between them it overfills and adds get rejected. A few adds lack a
    // handler, and a few periods are full 32-bit values that never expire.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == DRAIN_PAUSE_AT) begin
        // Hold the input back until the block has handed over everything it owes.
        in_valid <= 1'b0;
        do @(posedge clk_i); while (due_results.size() != 0);
        burst_left = 0;
      end
      pick = $urandom_range(99, 0);
      if (pick < 5)       item.operation = OP_CLEAR;
      else if (pick < 32) item.operation = OP_ADD;
      else if (pick < 68) item.operation = OP_TICK;
      else                item.operation = OP_RUN;
      pick = $urandom_range(99, 0);
      if (pick < 70)      item.period = $urandom_range(6, 0);
      else if (pick < 85) item.period = $urandom_range(30, 7);
      else                item.period = $urandom();
      item.handler_valid = ($urandom_range(9, 0) != 0);
      offer_item(item, 1'b0, typed_res);
    end
    in_valid <= 1'b0;

    // Let the block drain, then watch a little longer for any stray result.
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Ran %0d items: %0d ticks, %0d adds (%0d rejected), %0d runs (%0d empty), %0d clears.",
             DIRECTED_STEPS + RANDOM_ITEMS, op_counts[OP_TICK], op_counts[OP_ADD],
             rejected_adds, op_counts[OP_RUN], idle_runs, op_counts[OP_CLEAR]);
    $display("Checked %0d results; the busiest run dispatched %0d slots.",
             results_seen, most_dispatched);
    if (errors == 0) begin
      $display("periodic_task_dispatcher test passed");
    end else begin
      $display("periodic_task_dispatcher test failed");
    end
    $finish;
  end

  // Receiver: switches between stall patterns of its own. Once enough results have
  // arrived it holds off for a long stretch, so the output register fills and the
  // block stops taking items while the sender keeps offering them.
  initial begin : receiver
    int span;
    int pattern;
    @(posedge rst_ni);
    forever begin
      if (!long_hold_done && results_seen >= HOLD_AFTER_RESULTS) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        long_hold_done = 1'b1;
      end
      span    = $urandom_range(64, 16);
      pattern = $urandom_range(2, 0);
      repeat (span) begin
        case (pattern)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(9, 0) < 6);
          default: out_ready <= ($urandom_range(3, 0) == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Every result taken by the receiver is compared with the oldest one owed.
  always @(posedge clk_i) begin : result_check
    ptd_out_t want;
    if (rst_ni && out_valid && out_ready) begin
      results_seen++;
      if (due_results.size() == 0) begin
        $error("result with none owed: status %0d, task_index %0d, tick_count %0d",
               out_data.status, out_data.task_index, out_data.tick_count);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          errors++;
        end
        if (out_data.task_index !== want.task_index) begin
          $error("task_index: expected %0d, got %0d", want.task_index, out_data.task_index);
          errors++;
        end
        if (out_data.tick_count !== want.tick_count) begin
          $error("tick_count: expected %0d, got %0d", want.tick_count, out_data.tick_count);
          errors++;
        end
        if (out_data.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d", want.last_of_run, out_data.last_of_run);
          errors++;
        end
      end
    end
  end

  // Watchdog: a long spell without any handshake on either side ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("No handshake for %0d cycles, %0d results still owed.",
                 STALL_LIMIT, due_results.size());
        $display("periodic_task_dispatcher test failed");
        $finish;
      end
    end
  end

endmodule

FILE: periodic_task_dispatcher.f
+incdir+hdl
hdl/ptd_pkg.sv
hdl/ptd_ctrl.sv
hdl/ptd_dpath.sv
hdl/periodic_task_dispatcher.sv
dv/periodic_task_dispatcher_tb.sv
